@@ design/geo_pkg.sv @@
package geo_pkg;

    localparam int MaxCharsDefault     = 12;
    localparam int FractionBitsDefault = 32;
    localparam int SymbolBits          = 5;
    localparam int CellCount           = 5;

    typedef struct packed {
        logic                  valid;
        logic [3:0]            idx;
        logic [3:0]            cnt_m1;
        logic [SymbolBits-1:0] sym;
    } cell_ctl_t;

    function automatic logic [6:0] symbol_ascii(input logic [SymbolBits-1:0] s);
        logic [6:0] c;
        c = 7'd48;
        case (s)
            5'd0:  c = 7'd48;  5'd1:  c = 7'd49;  5'd2:  c = 7'd50;  5'd3:  c = 7'd51;
            5'd4:  c = 7'd52;  5'd5:  c = 7'd53;  5'd6:  c = 7'd54;  5'd7:  c = 7'd55;
            5'd8:  c = 7'd56;  5'd9:  c = 7'd57;  5'd10: c = 7'd98;  5'd11: c = 7'd99;
            5'd12: c = 7'd100; 5'd13: c = 7'd101; 5'd14: c = 7'd102; 5'd15: c = 7'd103;
            5'd16: c = 7'd104; 5'd17: c = 7'd106; 5'd18: c = 7'd107; 5'd19: c = 7'd109;
            5'd20: c = 7'd110; 5'd21: c = 7'd112; 5'd22: c = 7'd113; 5'd23: c = 7'd114;
            5'd24: c = 7'd115; 5'd25: c = 7'd116; 5'd26: c = 7'd117; 5'd27: c = 7'd118;
            5'd28: c = 7'd119; 5'd29: c = 7'd120; 5'd30: c = 7'd121; 5'd31: c = 7'd122;
            default: c = 7'd48;
        endcase
        return c;
    endfunction

endpackage

@@ design/geo_cell.sv @@
module geo_cell
    import geo_pkg::*;
#(
    parameter int                 BIT_POS = 0,
    parameter int                 LAT_W   = 40,
    parameter int                 LON_W   = 41,
    parameter logic [LAT_W-1:0]   LAT_SPAN = '0,
    parameter logic [LON_W-1:0]   LON_SPAN = '0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  cell_ctl_t        ctl_in,
    input  logic [LAT_W-1:0] lat_in,
    input  logic [LON_W-1:0] lon_in,
    output cell_ctl_t        ctl_out,
    output logic [LAT_W-1:0] lat_out,
    output logic [LON_W-1:0] lon_out
);

    localparam logic POS_ODD = 1'((BIT_POS % 2) == 1);

    logic             valid_reg;
    logic [3:0]       idx_reg;
    logic [3:0]       cnt_m1_reg;
    logic [4:0]       sym_reg;
    logic [LAT_W-1:0] lat_reg;
    logic [LON_W-1:0] lon_reg;

    logic             lon_turn;
    logic [LAT_W:0]   lat_d;
    logic [LON_W:0]   lon_d;
    logic             lat_gt;
    logic             lon_gt;
    logic             bit_val;
    logic [LAT_W-1:0] lat_next;
    logic [LON_W-1:0] lon_next;

    // global bit position 5k+b: longitude on even positions
    assign lon_turn = ~(POS_ODD ^ ctl_in.idx[0]);

    always_comb
    begin
        lat_d    = {lat_in, 1'b0};
        lon_d    = {lon_in, 1'b0};
        lat_gt   = lat_d > {1'b0, LAT_SPAN};
        lon_gt   = lon_d > {1'b0, LON_SPAN};
        lat_next = lat_in;
        lon_next = lon_in;
        if (lon_turn)
        begin
            bit_val  = lon_gt;
            lon_next = lon_gt ? LON_W'(lon_d - {1'b0, LON_SPAN}) : lon_d[LON_W-1:0];
        end
        else
        begin
            bit_val  = lat_gt;
            lat_next = lat_gt ? LAT_W'(lat_d - {1'b0, LAT_SPAN}) : lat_d[LAT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_reg    <= ctl_in.idx;
            cnt_m1_reg <= ctl_in.cnt_m1;
            sym_reg    <= {ctl_in.sym[3:0], bit_val};
            lat_reg    <= lat_next;
            lon_reg    <= lon_next;
        end
    end

    always_comb
    begin
        ctl_out.valid  = valid_reg;
        ctl_out.idx    = idx_reg;
        ctl_out.cnt_m1 = cnt_m1_reg;
        ctl_out.sym    = sym_reg;
    end

    assign lat_out = lat_reg;
    assign lon_out = lon_reg;

endmodule

@@ design/geohash_encoder.sv @@
// Geohash encoder: one point in, 1 to MAX_CHARS base-32 characters out.
// Input channel: latitude, longitude (signed degrees scaled by 2^FRACTION_BITS)
// and char_count, taken when in_valid is high and in_stall low. A count of zero
// gives one character; counts above MAX_CHARS are clamped. Coordinates out of
// range saturate to the interval bounds.
// Output channel: one beat per character (symbol_char, symbol_index, last),
// taken when out_valid is high and out_stall low; last marks the final beat.
// A row of five bisection cells produces one character; each cell makes one
// bit and passes its remainders on, and the fifth cell feeds the first for the
// next character. in_stall is high while a point is in the cell row and
// while out_stall holds a beat in the output register.
// When out_stall holds a beat in the output register the whole cell row
// freezes. Reset empties the cell row and the output register.
module geohash_encoder
    import geo_pkg::*;
#(
    parameter int MAX_CHARS     = MaxCharsDefault,
    parameter int FRACTION_BITS = FractionBitsDefault
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [FRACTION_BITS+7:0] latitude,
    input  logic signed [FRACTION_BITS+8:0] longitude,
    input  logic [3:0]                      char_count,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [6:0]                      symbol_char,
    output logic [4:0]                      symbol_index,
    output logic                            last
);

    localparam int LAT_W = FRACTION_BITS + 8;
    localparam int LON_W = FRACTION_BITS + 9;
    localparam logic [LAT_W-1:0] LAT_HALF = LAT_W'(64'd90 << FRACTION_BITS);
    localparam logic [LON_W-1:0] LON_HALF = LON_W'(64'd180 << FRACTION_BITS);
    localparam logic [LAT_W-1:0] LAT_SPAN = LAT_W'(64'd180 << FRACTION_BITS);
    localparam logic [LON_W-1:0] LON_SPAN = LON_W'(64'd360 << FRACTION_BITS);
    localparam logic [3:0]       MAX_M1   = 4'(MAX_CHARS - 1);

    cell_ctl_t        ctl [0:CellCount];
    logic [LAT_W-1:0] lat [0:CellCount];
    logic [LON_W-1:0] lon [0:CellCount];

    logic             en;
    logic             accept;
    logic             tail_last;
    logic             busy_reg;
    logic             busy_next;
    logic             out_valid_reg;
    logic [4:0]       sym_reg;
    logic             last_reg;
    logic [LAT_W-1:0] lat_u;
    logic [LON_W-1:0] lon_u;
    logic [3:0]       cnt_m1;

    assign en        = ~(out_valid_reg & out_stall);
    assign in_stall  = busy_reg | ~en;
    assign accept    = in_valid & ~in_stall;
    assign tail_last = ctl[CellCount].idx == ctl[CellCount].cnt_m1;

    always_comb
    begin
        if (latitude > $signed(LAT_HALF))
            lat_u = LAT_SPAN;
        else if (latitude < -$signed(LAT_HALF))
            lat_u = '0;
        else
            lat_u = LAT_W'(latitude) + LAT_HALF;

        if (longitude > $signed(LON_HALF))
            lon_u = LON_SPAN;
        else if (longitude < -$signed(LON_HALF))
            lon_u = '0;
        else
            lon_u = LON_W'(longitude) + LON_HALF;

        if (char_count == 4'd0)
            cnt_m1 = 4'd0;
        else if (char_count > 4'(MAX_CHARS))
            cnt_m1 = MAX_M1;
        else
            cnt_m1 = char_count - 4'd1;
    end

    // head of the row: a new point, or the next character of the current one
    always_comb
    begin
        if (accept)
        begin
            ctl[0].valid  = 1'b1;
            ctl[0].idx    = 4'd0;
            ctl[0].cnt_m1 = cnt_m1;
            ctl[0].sym    = '0;
            lat[0]        = lat_u;
            lon[0]        = lon_u;
        end
        else
        begin
            ctl[0].valid  = ctl[CellCount].valid & ~tail_last;
            ctl[0].idx    = ctl[CellCount].idx + 4'd1;
            ctl[0].cnt_m1 = ctl[CellCount].cnt_m1;
            ctl[0].sym    = '0;
            lat[0]        = lat[CellCount];
            lon[0]        = lon[CellCount];
        end
    end

    for (genvar i = 0; i < CellCount; i++)
    begin : g_cell
        geo_cell #(
            .BIT_POS  (i),
            .LAT_W    (LAT_W),
            .LON_W    (LON_W),
            .LAT_SPAN (LAT_SPAN),
            .LON_SPAN (LON_SPAN)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl[i]),
            .lat_in  (lat[i]),
            .lon_in  (lon[i]),
            .ctl_out (ctl[i+1]),
            .lat_out (lat[i+1]),
            .lon_out (lon[i+1])
        );
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (en && ctl[CellCount].valid && tail_last)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (en)
            begin
                out_valid_reg <= ctl[CellCount].valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && ctl[CellCount].valid)
        begin
            sym_reg  <= ctl[CellCount].sym;
            last_reg <= tail_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign symbol_index = sym_reg;
    assign symbol_char  = symbol_ascii(sym_reg);
    assign last         = last_reg;

endmodule
